// ----- rtl/mqspf_pkg.sv -----
// Shared constants and types for the multi-queue strict-priority FIFO.
package mqspf_pkg;

   localparam int NUM_QUEUES_DEF  = 8;
   localparam int CLASS_DEPTH_DEF = 64;
   localparam int NUM_CLASSES_DEF = 4;

   localparam int QUEUE_W  = 4;
   localparam int CLASS_W  = 2;
   localparam int ITEM_W   = 16;
   localparam int STATUS_W = 2;
   localparam int CSR_W    = 4;

   localparam logic [CSR_W-1:0] QUEUES_IN_USE_RST = 4'd8;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_BAD_QUEUE = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic {
      REQ_PUSH = 1'b0,
      REQ_POP  = 1'b1
   } req_kind_type;

endpackage

// ----- rtl/multi_queue_strict_priority_fifo.sv -----
// Multi-queue strict-priority FIFO: queues of class FIFOs kept in synchronous memories.
//
// Usage: a request (push or pop) is taken on a rising edge with start high and busy low.
// A push stores req_item_id at the tail of class req_priority_class (clamped to the
// lowest class) of queue req_queue_index. A pop returns the oldest item of the highest
// ranked non-empty class of the named queue. Every request yields exactly one response,
// shown for one cycle with rsp_valid high; the receiver cannot stall it.
// Sequence: a push, a rejected request or a pop of an empty queue passes through the
// execute state and responds from there; a successful pop goes on to a pop-read state
// for the item memory read and responds from that. The pointer memory is read at
// acceptance and written back in the execute state, in the next cycle. busy drops
// while the response shows, so the next request can be taken in that cycle.
// Configuration: csr_wr_en writes queues_in_use; write it only while the block is idle.
// Reset: synchronous; queues_in_use returns to 8 and all queues read as empty at once
// (per-slot valid bits stand in for the cleared pointer memory; no clearing pass).
module multi_queue_strict_priority_fifo #(
   parameter int NUM_QUEUES  = mqspf_pkg::NUM_QUEUES_DEF,
   parameter int CLASS_DEPTH = mqspf_pkg::CLASS_DEPTH_DEF,
   parameter int NUM_CLASSES = mqspf_pkg::NUM_CLASSES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_type,
   input  logic [mqspf_pkg::QUEUE_W-1:0]  req_queue_index,
   input  logic [mqspf_pkg::CLASS_W-1:0]  req_priority_class,
   input  logic [mqspf_pkg::ITEM_W-1:0]   req_item_id,
   output logic                           rsp_valid,
   output logic [mqspf_pkg::STATUS_W-1:0] rsp_status,
   output logic                           rsp_item_valid,
   output logic [mqspf_pkg::ITEM_W-1:0]   rsp_out_item_id,
   output logic [mqspf_pkg::CLASS_W-1:0]  rsp_out_class,
   input  logic                           csr_wr_en,
   input  logic [mqspf_pkg::CSR_W-1:0]    csr_wr_data
);
   import mqspf_pkg::*;

   localparam int NSLOT = NUM_QUEUES * NUM_CLASSES;
   localparam int SW    = $clog2(NSLOT);
   localparam int PW    = $clog2(CLASS_DEPTH);
   localparam int CW    = $clog2(CLASS_DEPTH + 1);
   localparam int CLW   = $clog2(NUM_CLASSES);
   localparam int EDEPTH = 1 << (SW + PW);

   typedef struct packed {
      logic [PW-1:0] head;
      logic [PW-1:0] tail;
      logic [CW-1:0] count;
   } slot_ptr_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_POP  = 3'b100
   } state_type;

   // memories
   slot_ptr_type      ptr_mem [NSLOT];
   logic [ITEM_W-1:0] entry_mem [EDEPTH];

   state_type         state_ff, state_in;
   logic [CSR_W-1:0]  queues_in_use_ff;
   logic [NSLOT-1:0]  slot_valid_ff;
   logic [NSLOT-1:0]  nonempty_ff;

   slot_ptr_type      ptr_rd_ff;
   logic [ITEM_W-1:0] entry_rd_ff;

   req_kind_type      kind_ff;
   logic [SW-1:0]     slot_ff, slot_in;
   logic [CLW-1:0]    cls_ff, cls_in;
   logic [ITEM_W-1:0] id_ff;
   logic              bad_ff, bad_in;
   logic              empty_ff, empty_in;

   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic              rsp_item_valid_ff;
   logic [ITEM_W-1:0] rsp_id_ff;
   logic [CLASS_W-1:0] rsp_class_ff;

   logic              accept;
   logic [SW-1:0]     slot_base;
   logic [NUM_CLASSES-1:0] ne_q;
   logic [CLW-1:0]    pop_cls;
   logic              pop_found;
   slot_ptr_type      eff;
   logic              full;
   logic              push_ok;
   logic              pop_ok;
   slot_ptr_type      ptr_wr;

   function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
      logic [PW-1:0] r;
      if (p == PW'(CLASS_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PW'(1);
      end
      return r;
   endfunction

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // request decode at acceptance
   always_comb begin
      bad_in = !(({1'b0, req_queue_index} < {1'b0, queues_in_use_ff}) &&
                 ({1'b0, req_queue_index} < 5'(NUM_QUEUES)));
      slot_base = bad_in ? '0 : SW'(SW'(req_queue_index) * SW'(NUM_CLASSES));
      for (int c = 0; c < NUM_CLASSES; c++) begin
         ne_q[c] = nonempty_ff[slot_base + SW'(c)];
      end
      pop_cls   = '0;
      pop_found = 1'b0;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if (ne_q[c]) begin
            pop_cls   = CLW'(c);
            pop_found = 1'b1;
         end
      end
      if (req_type == REQ_POP) begin
         cls_in = pop_cls;
      end else if (int'(req_priority_class) >= NUM_CLASSES) begin
         cls_in = CLW'(NUM_CLASSES - 1);
      end else begin
         cls_in = CLW'(req_priority_class);
      end
      empty_in = (req_type == REQ_POP) && !pop_found;
      slot_in  = slot_base + SW'(cls_in);
   end

   // read-modify-write of the slot pointers
   always_comb begin
      eff     = slot_valid_ff[slot_ff] ? ptr_rd_ff : '0;
      full    = (eff.count == CW'(CLASS_DEPTH));
      push_ok = (state_ff == S_EXEC) && !bad_ff && (kind_ff == REQ_PUSH) && !full;
      pop_ok  = (state_ff == S_EXEC) && !bad_ff && (kind_ff == REQ_POP) && !empty_ff;
      ptr_wr  = eff;
      if (push_ok) begin
         ptr_wr.tail  = advance(eff.tail);
         ptr_wr.count = eff.count + CW'(1);
      end else if (pop_ok) begin
         ptr_wr.head  = advance(eff.head);
         ptr_wr.count = eff.count - CW'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = pop_ok ? S_POP : S_IDLE;
         end
         S_POP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // memories and payload
   always_ff @(posedge clock) begin
      if (accept) begin
         ptr_rd_ff <= ptr_mem[slot_in];
         kind_ff   <= req_kind_type'(req_type);
         slot_ff   <= slot_in;
         cls_ff    <= cls_in;
         id_ff     <= req_item_id;
         bad_ff    <= bad_in;
         empty_ff  <= empty_in;
      end
      if (push_ok || pop_ok) begin
         ptr_mem[slot_ff] <= ptr_wr;
      end
      if (push_ok) begin
         entry_mem[{slot_ff, eff.tail}] <= id_ff;
      end
      if (pop_ok) begin
         entry_rd_ff <= entry_mem[{slot_ff, eff.head}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         queues_in_use_ff  <= QUEUES_IN_USE_RST;
         slot_valid_ff     <= '0;
         nonempty_ff       <= '0;
         rsp_valid_ff      <= 1'b0;
         rsp_status_ff     <= ST_OK;
         rsp_item_valid_ff <= 1'b0;
         rsp_id_ff         <= '0;
         rsp_class_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            queues_in_use_ff <= csr_wr_data;
         end
         if (push_ok || pop_ok) begin
            slot_valid_ff[slot_ff] <= 1'b1;
            nonempty_ff[slot_ff]   <= (ptr_wr.count != '0);
         end
         if (state_ff == S_EXEC && !pop_ok) begin
            rsp_valid_ff      <= 1'b1;
            rsp_item_valid_ff <= 1'b0;
            rsp_id_ff         <= '0;
            rsp_class_ff      <= '0;
            if (bad_ff) begin
               rsp_status_ff <= ST_BAD_QUEUE;
            end else if (kind_ff == REQ_POP) begin
               rsp_status_ff <= ST_EMPTY;
            end else if (full) begin
               rsp_status_ff <= ST_FULL;
            end else begin
               rsp_status_ff <= ST_OK;
            end
         end else if (state_ff == S_POP) begin
            rsp_valid_ff      <= 1'b1;
            rsp_status_ff     <= ST_OK;
            rsp_item_valid_ff <= 1'b1;
            rsp_id_ff         <= entry_rd_ff;
            rsp_class_ff      <= CLASS_W'(cls_ff);
         end else begin
            rsp_valid_ff      <= 1'b0;
            rsp_item_valid_ff <= 1'b0;
            rsp_id_ff         <= '0;
            rsp_class_ff      <= '0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_item_valid  = rsp_item_valid_ff;
   assign rsp_out_item_id = rsp_id_ff;
   assign rsp_out_class   = rsp_class_ff;

   // each accepted request is worked on in the following cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted request did not enter execute");

   // a response follows only execute or pop-read cycles
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == S_EXEC || $past(state_ff) == S_POP))
      else $error("response without a request in flight");

   // pop-read stage only follows a successful pop
   a_pop_after_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |-> ($past(pop_ok) && $past(kind_ff) == REQ_POP))
      else $error("item read without a pop");

   // a returned item always carries ok status
   a_item_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item_valid) |-> (rsp_status == ST_OK))
      else $error("item returned with error status");

   // push and pop never update the pointers in the same cycle
   a_no_push_pop: assert property (@(posedge clock) disable iff (reset)
      !(push_ok && pop_ok))
      else $error("push and pop update in the same cycle");

endmodule

// ----- verif/tb_multi_queue_strict_priority_fifo.sv -----
// Self-checking testbench for the multi-queue strict-priority FIFO.
`timescale 1ns / 100ps

module tb_multi_queue_strict_priority_fifo;
   import mqspf_pkg::*;

   localparam int NQ             = NUM_QUEUES_DEF;
   localparam int NC             = NUM_CLASSES_DEF;
   localparam int DEPTH          = CLASS_DEPTH_DEF;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int NUM_PHASES     = 6;
   localparam int NUM_DIRECTED   = 21;

   typedef struct packed {
      req_kind_type        kind;
      logic [QUEUE_W-1:0]  queue;
      logic [CLASS_W-1:0]  cls;
      logic [ITEM_W-1:0]   id;
   } queue_request_t;

   typedef struct packed {
      status_type          status;
      logic                item_valid;
      logic [ITEM_W-1:0]   item_id;
      logic [CLASS_W-1:0]  cls;
   } queue_result_t;

   typedef struct packed {
      queue_request_t req;
      logic           fixed;
      queue_result_t  lit;
   } directed_row_t;

   localparam queue_result_t NO_ITEM = '{ST_OK, 1'b0, 16'h0000, 2'd0};

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_type;
   logic [QUEUE_W-1:0]  req_queue_index;
   logic [CLASS_W-1:0]  req_priority_class;
   logic [ITEM_W-1:0]   req_item_id;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_item_valid;
   logic [ITEM_W-1:0]   rsp_out_item_id;
   logic [CLASS_W-1:0]  rsp_out_class;
   logic                csr_wr_en;
   logic [CSR_W-1:0]    csr_wr_data;

   multi_queue_strict_priority_fifo u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_queue_index    (req_queue_index),
      .req_priority_class (req_priority_class),
      .req_item_id        (req_item_id),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_item_valid     (rsp_item_valid),
      .rsp_out_item_id    (rsp_out_item_id),
      .rsp_out_class      (rsp_out_class),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // shadow copy of the queues
   logic [ITEM_W-1:0] shadow_items [NQ][NC][DEPTH];
   int                head_ptr     [NQ][NC];
   int                tail_ptr     [NQ][NC];
   int                fill_level   [NQ][NC];
   logic [CSR_W-1:0]  queues_enabled;

   queue_result_t     pending_results [$];
   logic              fixed_flag;
   queue_result_t     fixed_result;
   int                idle_pct;
   int                quiet_cycles;
   int                mismatch_count;
   int                request_total;
   int                popped_count;
   int                empty_count;
   int                rejected_count;
   int                dropped_count;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic queue_result_t predict_request(queue_request_t r);
      queue_result_t res;
      int            c;
      int            q;
      bit            found;
      res   = NO_ITEM;
      q     = r.queue;
      found = 1'b0;
      if (r.queue >= queues_enabled || q >= NQ) begin
         res.status = ST_BAD_QUEUE;
         return res;
      end
      if (r.kind == REQ_PUSH) begin
         c = (r.cls >= NC) ? NC - 1 : r.cls;
         if (fill_level[q][c] >= DEPTH) begin
            res.status = ST_FULL;
         end else begin
            shadow_items[q][c][tail_ptr[q][c]] = r.id;
            tail_ptr[q][c] = (tail_ptr[q][c] + 1 >= DEPTH) ? 0 : tail_ptr[q][c] + 1;
            fill_level[q][c]++;
         end
         return res;
      end
      for (c = 0; c < NC; c++) begin
         if (!found && fill_level[q][c] != 0) begin
            found          = 1'b1;
            res.item_valid = 1'b1;
            res.item_id    = shadow_items[q][c][head_ptr[q][c]];
            res.cls        = c[CLASS_W-1:0];
            head_ptr[q][c] = (head_ptr[q][c] + 1 >= DEPTH) ? 0 : head_ptr[q][c] + 1;
            fill_level[q][c]--;
         end
      end
      if (!found) res.status = ST_EMPTY;
      return res;
   endfunction

   // response check, request capture and watchdog, all on the rising edge
   always @(posedge clock) begin
      queue_result_t exp_res;
      queue_result_t got_res;
      bit            taken;
      if (!reset) begin
         taken = start && !busy;
         if (csr_wr_en) queues_enabled = csr_wr_data;
         if (rsp_valid) begin
            got_res = '{status_type'(rsp_status), rsp_item_valid, rsp_out_item_id,
                        rsp_out_class};
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: response with no request outstanding: status=%0d",
                           $time, rsp_status);
            end else begin
               exp_res = pending_results.pop_front();
               if (got_res.status != exp_res.status ||
                   got_res.item_valid != exp_res.item_valid ||
                   got_res.item_id != exp_res.item_id ||
                   got_res.cls != exp_res.cls) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: mismatch exp status=%0d valid=%0d id=%h class=%0d, got status=%0d valid=%0d id=%h class=%0d",
                              $time, exp_res.status, exp_res.item_valid, exp_res.item_id,
                              exp_res.cls, got_res.status, got_res.item_valid,
                              got_res.item_id, got_res.cls);
               end
            end
         end
         if (taken) begin
            exp_res = predict_request('{req_kind_type'(req_type), req_queue_index,
                                        req_priority_class, req_item_id});
            if (fixed_flag) exp_res = fixed_result;
            pending_results.push_back(exp_res);
            request_total++;
            case (exp_res.status)
               ST_OK:        if (exp_res.item_valid) popped_count++;
               ST_EMPTY:     empty_count++;
               ST_BAD_QUEUE: rejected_count++;
               ST_FULL:      dropped_count++;
               default: ;
            endcase
         end
         if (taken || rsp_valid) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input queue_request_t r, input logic fixed,
                               input queue_result_t lit);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      req_type           = r.kind;
      req_queue_index    = r.queue;
      req_priority_class = r.cls;
      req_item_id        = r.id;
      fixed_flag         = fixed;
      fixed_result       = lit;
      start              = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic wait_until_drained();
      start = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   initial begin
      directed_row_t  directed_rows [NUM_DIRECTED];
      int             qiu_plan  [NUM_PHASES];
      int             idle_plan [NUM_PHASES];
      int             count_plan[NUM_PHASES];
      int             push_plan [NUM_PHASES];
      queue_request_t r;
      int             active_queues;
      int             burst_left;
      req_kind_type   burst_kind;
      int             burst_queue;
      int             burst_class;

      directed_rows = '{
         '{'{REQ_POP,  4'd0,  2'd0, 16'h0000}, 1'b1, '{ST_EMPTY,     1'b0, 16'h0, 2'd0}},
         '{'{REQ_POP,  4'd7,  2'd3, 16'hFFFF}, 1'b1, '{ST_EMPTY,     1'b0, 16'h0, 2'd0}},
         '{'{REQ_PUSH, 4'd8,  2'd0, 16'h0001}, 1'b1, '{ST_BAD_QUEUE, 1'b0, 16'h0, 2'd0}},
         '{'{REQ_POP,  4'd15, 2'd0, 16'h0000}, 1'b1, '{ST_BAD_QUEUE, 1'b0, 16'h0, 2'd0}},
         '{'{REQ_PUSH, 4'd0,  2'd3, 16'hFFFF}, 1'b1, '{ST_OK,        1'b0, 16'h0, 2'd0}},
         '{'{REQ_PUSH, 4'd0,  2'd0, 16'h0000}, 1'b1, '{ST_OK,        1'b0, 16'h0, 2'd0}},
         '{'{REQ_PUSH, 4'd0,  2'd2, 16'h1234}, 1'b0, NO_ITEM},
         '{'{REQ_PUSH, 4'd0,  2'd1, 16'hA5A5}, 1'b0, NO_ITEM},
         '{'{REQ_PUSH, 4'd0,  2'd0, 16'h5A5A}, 1'b0, NO_ITEM},
         '{'{REQ_POP,  4'd0,  2'd3, 16'hFFFF}, 1'b0, NO_ITEM},
         '{'{REQ_POP,  4'd0,  2'd0, 16'h0000}, 1'b0, NO_ITEM},
         '{'{REQ_POP,  4'd0,  2'd2, 16'h0F0F}, 1'b0, NO_ITEM},
         '{'{REQ_POP,  4'd0,  2'd1, 16'h0000}, 1'b0, NO_ITEM},
         '{'{REQ_POP,  4'd0,  2'd0, 16'hF0F0}, 1'b0, NO_ITEM},
         '{'{REQ_POP,  4'd0,  2'd0, 16'h0000}, 1'b1, '{ST_EMPTY,     1'b0, 16'h0, 2'd0}},
         '{'{REQ_PUSH, 4'd7,  2'd2, 16'h8001}, 1'b0, NO_ITEM},
         '{'{REQ_PUSH, 4'd7,  2'd2, 16'h7FFE}, 1'b0, NO_ITEM},
         '{'{REQ_POP,  4'd7,  2'd1, 16'h0000}, 1'b0, NO_ITEM},
         '{'{REQ_PUSH, 4'd15, 2'd1, 16'hABCD}, 1'b1, '{ST_BAD_QUEUE, 1'b0, 16'h0, 2'd0}},
         '{'{REQ_POP,  4'd7,  2'd3, 16'hFFFF}, 1'b0, NO_ITEM},
         '{'{REQ_POP,  4'd7,  2'd0, 16'h0000}, 1'b1, '{ST_EMPTY,     1'b0, 16'h0, 2'd0}}
      };
      // csr setting, sender idle percent, request count, push percent per phase
      qiu_plan   = '{15, 1, 0, 3, 8, 2};
      idle_plan  = '{6, 6, 65, 65, 0, 0};
      count_plan = '{150, 110, 30, 150, 110, 60};
      push_plan  = '{55, 70, 50, 60, 45, 50};

      reset              = 1'b1;
      start              = 1'b0;
      req_type           = REQ_PUSH;
      req_queue_index    = '0;
      req_priority_class = '0;
      req_item_id        = '0;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      fixed_flag         = 1'b0;
      fixed_result       = NO_ITEM;
      queues_enabled     = QUEUES_IN_USE_RST;
      idle_pct           = idle_plan[0];
      quiet_cycles       = 0;
      mismatch_count     = 0;
      request_total      = 0;
      popped_count       = 0;
      empty_count        = 0;
      rejected_count     = 0;
      dropped_count      = 0;
      burst_left         = 0;
      burst_kind         = REQ_PUSH;
      burst_queue        = 0;
      burst_class        = 0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++)
         send_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].lit);

      for (int p = 0; p < NUM_PHASES; p++) begin
         // csr only changes with no request outstanding
         wait_until_drained();
         csr_wr_en   = 1'b1;
         csr_wr_data = qiu_plan[p][CSR_W-1:0];
         @(negedge clock);
         csr_wr_en   = 1'b0;
         idle_pct    = idle_plan[p];
         active_queues = (qiu_plan[p] > NQ) ? NQ : qiu_plan[p];
         burst_left  = 0;
         for (int n = 0; n < count_plan[p]; n++) begin
            // bursts on one queue and class reach full classes and deep drains
            if (burst_left == 0 && active_queues > 0 && $urandom_range(7) == 0) begin
               burst_left  = $urandom_range(70, 10);
               burst_kind  = ($urandom_range(1) == 1) ? REQ_POP : REQ_PUSH;
               burst_queue = $urandom_range(active_queues - 1);
               burst_class = $urandom_range(NC - 1);
            end
            r.id  = ITEM_W'($urandom);
            r.cls = CLASS_W'($urandom_range(3));
            if (burst_left > 0) begin
               burst_left--;
               r.kind  = burst_kind;
               r.queue = QUEUE_W'(burst_queue);
               if (burst_kind == REQ_PUSH) r.cls = CLASS_W'(burst_class);
            end else begin
               r.kind = ($urandom_range(99) < push_plan[p]) ? REQ_PUSH : REQ_POP;
               if (active_queues == 0 || $urandom_range(99) < 12)
                  r.queue = QUEUE_W'($urandom_range(15));
               else
                  r.queue = QUEUE_W'($urandom_range(active_queues - 1));
            end
            send_request(r, 1'b0, NO_ITEM);
         end
      end

      wait_until_drained();
      repeat (6) @(negedge clock);
      $display("Covered %0d requests over %0d csr settings after the directed table:",
               request_total, NUM_PHASES);
      $display("  %0d items popped, %0d empty pops, %0d bad indices, %0d full-class drops",
               popped_count, empty_count, rejected_count, dropped_count);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatch_count,
                  pending_results.size());
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/mqspf_pkg.sv
rtl/multi_queue_strict_priority_fifo.sv
verif/tb_multi_queue_strict_priority_fifo.sv
